### rtl/core/crc32c_pkg.sv
// ----------------------------------------------------------------------------
// crc32c_pkg
// Shared types, constants and advance tables for the CRC-32C stream engine.
// ----------------------------------------------------------------------------
`default_nettype none

package crc32c_pkg;

   localparam int BYTES_PER_WORD = 8;
   localparam int DATA_W         = 64;
   localparam int CRC_W          = 32;
   localparam int COUNT_W        = $clog2(BYTES_PER_WORD + 1);

   localparam logic [CRC_W-1:0] CRC_POLY_REFL = 32'h82F6_3B78;
   localparam logic [CRC_W-1:0] CRC_INVERT    = 32'hFFFF_FFFF;

   // Column k of entry m: the state with only bit k set, run through m zero bytes.
   typedef logic [BYTES_PER_WORD:0][CRC_W-1:0][CRC_W-1:0] adv_table_type;

   typedef logic [BYTES_PER_WORD-1:0][CRC_W-1:0] lane_array_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               first;
      logic [CRC_W-1:0]   seed_crc;
      logic               last;
   } word_info_type;

   typedef struct packed {
      logic load;
      logic drain;
   } stage_ctrl_type;

   typedef struct packed {
      logic advance;
      logic take;
   } out_ctrl_type;

   function automatic adv_table_type build_adv_table();
      adv_table_type    tbl;
      logic [CRC_W-1:0] v;
      tbl = '0;
      for (int m = 0; m <= BYTES_PER_WORD; m++) begin
         for (int k = 0; k < CRC_W; k++) begin
            v = CRC_W'(1) << k;
            for (int s = 0; s < 8 * m; s++) begin
               v = (v >> 1) ^ (v[0] ? CRC_POLY_REFL : '0);
            end
            tbl[m][k] = v;
         end
      end
      return tbl;
   endfunction

   localparam adv_table_type ADV_TABLE = build_adv_table();

   // Advance a state through m zero bytes: XOR of the table columns picked by c.
   function automatic logic [CRC_W-1:0] adv_apply(logic [CRC_W-1:0] c,
                                                  logic [COUNT_W-1:0] m);
      logic [CRC_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < CRC_W; k++) begin
         if (c[k]) begin
            acc = acc ^ ADV_TABLE[m][k];
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

### rtl/core/crc32c_req_if.sv
// ----------------------------------------------------------------------------
// crc32c_req_if
// Input word channel: valid/ready handshake with message bytes and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface crc32c_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_word;
   logic [3:0]  byte_count;
   logic        first;
   logic [31:0] seed_crc;
   logic        last;

   modport source (output valid, output data_word, output byte_count, output first,
                   output seed_crc, output last, input ready);
   modport sink   (input valid, input data_word, input byte_count, input first,
                   input seed_crc, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/crc32c_rsp_if.sv
// ----------------------------------------------------------------------------
// crc32c_rsp_if
// Result channel: valid/ready handshake with the finalized CRC and end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface crc32c_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] crc_value;
   logic        done_res;

   modport source (output valid, output crc_value, output done_res, input ready);
   modport sink   (input valid, input crc_value, input done_res, output ready);
endinterface

`default_nettype wire

### rtl/core/crc32c_wide_stream.sv
// ----------------------------------------------------------------------------
// crc32c_wide_stream
// Reflected CRC-32C over a stream of 64-bit words, one to eight bytes each.
// ----------------------------------------------------------------------------
// Path: an accepted word is registered in the lane stage, then, once the output
//   register advances, in the merge stage's state register, which drives its result.
// Throughput: one word per cycle while the result channel is ready; the running CRC
//   loop closes within the merge stage (state advance table plus XOR of the lane results).
// Reset: synchronous, active high; clears both valid flags and sets the
//   running CRC to all ones, the same as a fresh message with a zero seed.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32c_wide_stream (
   input  wire logic  clock,
   input  wire logic  reset,
   crc32c_req_if.sink   req_chan,
   crc32c_rsp_if.source rsp_chan
);

   // Stage one: eight byte lanes, each a fixed GF(2) map of its byte to the
   // CRC contribution that byte makes by the end of the word. The valid bytes
   // are right-aligned into the top lanes first, so the distance is constant.
   // Stage two: merge the lanes and advance the start state (the seed when the
   // word opens a message, else the running CRC) by the byte count. The state
   // register doubles as the output register.

   logic                        s1_valid;
   crc32c_pkg::lane_array_type  s1_lanes;
   crc32c_pkg::word_info_type   s1_info;
   crc32c_pkg::stage_ctrl_type  s1_ctrl;
   crc32c_pkg::out_ctrl_type    out_ctrl;
   logic                        out_valid;
   logic                        advance;

   // Advance the output register when it is empty or the word is taken.
   assign advance = !out_valid || rsp_chan.ready;

   // Accept a new word whenever stage one is empty or drains this cycle.
   assign req_chan.ready = !s1_valid || advance;

   always_comb begin
      s1_ctrl.load    = req_chan.valid && req_chan.ready;
      s1_ctrl.drain   = s1_valid && advance;
      out_ctrl.advance = advance;
      out_ctrl.take    = s1_valid && advance;
   end

   crc32c_lanes u_lanes (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (s1_ctrl),
      .data_word  (req_chan.data_word),
      .byte_count (req_chan.byte_count),
      .first      (req_chan.first),
      .seed_crc   (req_chan.seed_crc),
      .last       (req_chan.last),
      .valid      (s1_valid),
      .lanes      (s1_lanes),
      .info       (s1_info)
   );

   crc32c_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (out_ctrl),
      .in_valid  (s1_valid),
      .lanes     (s1_lanes),
      .info      (s1_info),
      .out_valid (out_valid),
      .crc_value (rsp_chan.crc_value),
      .done_res  (rsp_chan.done_res)
   );

   assign rsp_chan.valid = out_valid;

endmodule

`default_nettype wire

### rtl/core/crc32c_lanes.sv
// ----------------------------------------------------------------------------
// crc32c_lanes
// Byte lanes: align the valid bytes and find each byte's CRC contribution.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32c_lanes (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire crc32c_pkg::stage_ctrl_type           ctrl,
   input  wire logic [crc32c_pkg::DATA_W-1:0]        data_word,
   input  wire logic [3:0]                           byte_count,
   input  wire logic                                 first,
   input  wire logic [crc32c_pkg::CRC_W-1:0]         seed_crc,
   input  wire logic                                 last,
   output      logic                                 valid,
   output      crc32c_pkg::lane_array_type           lanes,
   output      crc32c_pkg::word_info_type            info
);

   localparam int BPW     = crc32c_pkg::BYTES_PER_WORD;
   localparam int CW      = crc32c_pkg::COUNT_W;
   localparam int DBYTES  = crc32c_pkg::DATA_W / 8;

   logic                       valid_ff, valid_in;
   crc32c_pkg::lane_array_type lanes_ff, lanes_in;
   crc32c_pkg::word_info_type  info_ff, info_in;
   logic [CW-1:0]              count_sat;
   logic [BPW-1:0][7:0]        lane_byte;

   // Saturate the count to the lane count.
   always_comb begin
      if (int'(byte_count) > BPW) begin
         count_sat = CW'(BPW);
      end else begin
         count_sat = CW'(byte_count);
      end
   end

   // Right-align the message into the top lanes: leading zero bytes leave a
   // zero state unchanged, so every lane can use a fixed distance to the end.
   always_comb begin
      for (int j = 0; j < BPW; j++) begin
         lane_byte[j] = '0;
         if ((j + int'(count_sat) >= BPW) && (j + int'(count_sat) - BPW < DBYTES)) begin
            lane_byte[j] = data_word[8 * (j + int'(count_sat) - BPW) +: 8];
         end
      end
   end

   always_comb begin
      for (int j = 0; j < BPW; j++) begin
         lanes_in[j] = '0;
         for (int k = 0; k < 8; k++) begin
            if (lane_byte[j][k]) begin
               lanes_in[j] = lanes_in[j] ^ crc32c_pkg::ADV_TABLE[BPW - j][k];
            end
         end
      end
   end

   always_comb begin
      info_in.count    = count_sat;
      info_in.first    = first;
      info_in.seed_crc = seed_crc;
      info_in.last     = last;
   end

   always_comb begin
      if (ctrl.load) begin
         valid_in = 1'b1;
      end else if (ctrl.drain) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload unless a new word loads.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         lanes_ff <= lanes_in;
         info_ff  <= info_in;
      end
   end

   assign valid = valid_ff;
   assign lanes = lanes_ff;
   assign info  = info_ff;

endmodule

`default_nettype wire

### rtl/core/crc32c_merge.sv
// ----------------------------------------------------------------------------
// crc32c_merge
// Merge stage: fold the lane results into the running CRC, drive the result.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32c_merge (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire crc32c_pkg::out_ctrl_type             ctrl,
   input  wire logic                                 in_valid,
   input  wire crc32c_pkg::lane_array_type           lanes,
   input  wire crc32c_pkg::word_info_type            info,
   output      logic                                 out_valid,
   output      logic [crc32c_pkg::CRC_W-1:0]         crc_value,
   output      logic                                 done_res
);

   localparam int BPW = crc32c_pkg::BYTES_PER_WORD;
   localparam int CRCW = crc32c_pkg::CRC_W;

   logic [CRCW-1:0] state_ff, state_in;
   logic [CRCW-1:0] start_crc;
   logic [CRCW-1:0] lane_sum;
   logic            valid_ff, valid_in;
   logic            done_ff;

   always_comb begin
      if (info.first) begin
         start_crc = info.seed_crc ^ crc32c_pkg::CRC_INVERT;
      end else begin
         start_crc = state_ff;
      end
   end

   always_comb begin
      lane_sum = '0;
      for (int j = 0; j < BPW; j++) begin
         lane_sum = lane_sum ^ lanes[j];
      end
   end

   assign state_in = crc32c_pkg::adv_apply(start_crc, info.count) ^ lane_sum;
   assign valid_in = ctrl.advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crc32c_pkg::CRC_INVERT;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctrl.take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         done_ff <= info.last;
      end
   end

   assign out_valid = valid_ff;
   assign crc_value = state_ff ^ crc32c_pkg::CRC_INVERT;
   assign done_res  = done_ff;

endmodule

`default_nettype wire
